/* rtl/acss_pkg.sv */
// ----------------------------------------------------------------------------
// ADC channel scan sequencer package
// Command and action codes, field widths and default settings shared by the
// scan sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int CMD_W      = 2;
    localparam int HOLD_W     = 4;
    localparam int CODE_W     = 24;
    localparam int ACTION_W   = 4;
    localparam int CHAN_OUT_W = 4;
    localparam int SETTLE_W   = 8;

    localparam int                  DEF_CHANNELS     = 16;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET_VAL = 8'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_HOLD    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE       = 4'd0,
        ACT_OPEN       = 4'd1,
        ACT_OPEN_HOLD  = 4'd2,
        ACT_START_CONV = 4'd3,
        ACT_TRIG_I     = 4'd4,
        ACT_STORE_I    = 4'd5,
        ACT_TRIG_V     = 4'd6,
        ACT_STORE_V    = 4'd7,
        ACT_RESET_MUX  = 4'd8
    } action_t;

endpackage

/* rtl/acss_cmd_if.sv */
// ----------------------------------------------------------------------------
// Scan command channel
// Valid/ready channel that carries one command word into the sequencer.
// ----------------------------------------------------------------------------
interface acss_cmd_if
    import acss_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [HOLD_W-1:0] hold_channel;
    logic [CODE_W-1:0] adc_code;

    modport source (output valid, output command, output hold_channel, output adc_code,
                    input ready);
    modport sink   (input valid, input command, input hold_channel, input adc_code,
                    output ready);

endinterface

/* rtl/acss_res_if.sv */
// ----------------------------------------------------------------------------
// Scan result channel
// Valid/ready channel that carries one action word out of the sequencer.
// ----------------------------------------------------------------------------
interface acss_res_if
    import acss_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [CHAN_OUT_W-1:0] channel;
    logic [CODE_W-1:0]     code;

    modport source (output valid, output action, output channel, output code,
                    input ready);
    modport sink   (input valid, input action, input channel, input code,
                    output ready);

endinterface

/* rtl/adc_channel_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Steps a round-robin scan over the converter channels, one action word per
// command word, with hold-on-channel and release commands.
// ----------------------------------------------------------------------------
//  Channel     Direction  Words
//  cmd         in         command, hold_channel, adc_code
//  res         out        action, channel, code
//  cfg_we/data in         settle_ticks register write
//
// Every command word yields exactly one action word; an accepted command word
// passes through the command register, then the result register, to res.
// One word per cycle is sustained while res is ready; the command register and
// the result register each hold one word, so a stall on the result side backs
// up into cmd.ready after those two places fill.
// Reset clears the scan state, sets settle_ticks to 4 and empties both stages.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SETTLE_W-1:0] cfg_wdata,
    acss_cmd_if.sink            cmd,
    acss_res_if.source          res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_OPEN   = 4'd1,
        PH_SETTLE = 4'd2,
        PH_TRIG_I = 4'd3,
        PH_READ_I = 4'd4,
        PH_TRIG_V = 4'd5,
        PH_READ_V = 4'd6,
        PH_CLOSE  = 4'd7,
        PH_PARKED = 4'd8
    } phase_t;

    logic [SETTLE_W-1:0] settle_ticks_reg;

    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [HOLD_W-1:0]   in_hold_reg;
    logic [CODE_W-1:0]   in_code_reg;

    phase_t              phase_reg, phase_next;
    logic [SETTLE_W-1:0] settle_count_reg, settle_count_next;
    logic [CH_W-1:0]     scan_channel_reg, scan_channel_next;
    logic [CH_W-1:0]     saved_channel_reg, saved_channel_next;
    logic [CH_W-1:0]     parked_channel_reg, parked_channel_next;
    logic                hold_active_reg, hold_active_next;

    logic                  out_valid_reg;
    action_t               action_reg, action_next;
    logic [CHAN_OUT_W-1:0] channel_reg, channel_next;
    logic [CODE_W-1:0]     code_reg, code_next;

    logic                  advance;
    logic                  in_take;
    logic [SETTLE_W-1:0]   settle_inc;
    logic [CH_W-1:0]       hold_clamped;
    logic [CH_W-1:0]       scan_inc;

    assign advance = in_valid_reg && (!out_valid_reg || res.ready);
    assign in_take = cmd.valid && cmd.ready;
    assign cmd.ready = !in_valid_reg || advance;

    assign settle_inc   = settle_count_reg + SETTLE_W'(1);
    assign hold_clamped = (32'(in_hold_reg) >= CHANNELS) ? CH_W'(CHANNELS - 1)
                                                         : CH_W'(in_hold_reg);
    assign scan_inc     = (32'(scan_channel_reg) + 32'd1 >= CHANNELS) ? '0
                                                                      : scan_channel_reg + 1'b1;

    always_comb
    begin
        phase_next          = phase_reg;
        settle_count_next   = settle_count_reg;
        scan_channel_next   = scan_channel_reg;
        saved_channel_next  = saved_channel_reg;
        parked_channel_next = parked_channel_reg;
        hold_active_next    = hold_active_reg;
        action_next         = ACT_NONE;
        channel_next        = '0;
        code_next           = '0;

        unique case (cmd_t'(in_cmd_reg))
            CMD_HOLD:
            begin
                saved_channel_next  = scan_channel_reg;
                parked_channel_next = hold_clamped;
                hold_active_next    = 1'b1;
            end
            CMD_RELEASE:
            begin
                scan_channel_next = saved_channel_reg;
                hold_active_next  = 1'b0;
                phase_next        = PH_IDLE;
                action_next       = ACT_RESET_MUX;
                channel_next      = CHAN_OUT_W'(saved_channel_reg);
            end
            CMD_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next        = PH_OPEN;
                        settle_count_next = '0;
                        scan_channel_next = '0;
                    end
                    PH_OPEN:
                    begin
                        settle_count_next = '0;
                        if (hold_active_reg)
                        begin
                            scan_channel_next = parked_channel_reg;
                            phase_next        = PH_PARKED;
                            action_next       = ACT_OPEN_HOLD;
                            channel_next      = CHAN_OUT_W'(parked_channel_reg);
                        end
                        else
                        begin
                            phase_next   = PH_SETTLE;
                            action_next  = ACT_OPEN;
                            channel_next = CHAN_OUT_W'(scan_channel_reg);
                        end
                    end
                    PH_SETTLE:
                    begin
                        if (settle_inc >= settle_ticks_reg)
                        begin
                            settle_count_next = '0;
                            phase_next        = PH_TRIG_I;
                            action_next       = ACT_START_CONV;
                            channel_next      = CHAN_OUT_W'(scan_channel_reg);
                        end
                        else
                        begin
                            settle_count_next = settle_inc;
                        end
                    end
                    PH_TRIG_I:
                    begin
                        phase_next   = PH_READ_I;
                        action_next  = ACT_TRIG_I;
                        channel_next = CHAN_OUT_W'(scan_channel_reg);
                    end
                    PH_READ_I:
                    begin
                        phase_next   = PH_TRIG_V;
                        action_next  = ACT_STORE_I;
                        channel_next = CHAN_OUT_W'(scan_channel_reg);
                        code_next    = in_code_reg;
                    end
                    PH_TRIG_V:
                    begin
                        phase_next   = PH_READ_V;
                        action_next  = ACT_TRIG_V;
                        channel_next = CHAN_OUT_W'(scan_channel_reg);
                    end
                    PH_READ_V:
                    begin
                        phase_next   = PH_CLOSE;
                        action_next  = ACT_STORE_V;
                        channel_next = CHAN_OUT_W'(scan_channel_reg);
                        code_next    = in_code_reg;
                    end
                    PH_CLOSE:
                    begin
                        if (!hold_active_reg)
                        begin
                            scan_channel_next = scan_inc;
                        end
                        phase_next   = PH_OPEN;
                        action_next  = ACT_RESET_MUX;
                        channel_next = CHAN_OUT_W'(scan_channel_reg);
                    end
                    PH_PARKED:
                    begin
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg   <= SETTLE_RESET_VAL;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_IDLE;
            settle_count_reg   <= '0;
            scan_channel_reg   <= '0;
            saved_channel_reg  <= '0;
            parked_channel_reg <= '0;
            hold_active_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                settle_ticks_reg <= cfg_wdata;
            end
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                phase_reg          <= phase_next;
                settle_count_reg   <= settle_count_next;
                scan_channel_reg   <= scan_channel_next;
                saved_channel_reg  <= saved_channel_next;
                parked_channel_reg <= parked_channel_next;
                hold_active_reg    <= hold_active_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= cmd.command;
            in_hold_reg <= cmd.hold_channel;
            in_code_reg <= cmd.adc_code;
        end
        if (advance)
        begin
            action_reg  <= action_next;
            channel_reg <= channel_next;
            code_reg    <= code_next;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.action  = action_reg;
    assign res.channel = channel_reg;
    assign res.code    = code_reg;

endmodule

/* sim/adc_channel_scan_sequencer_test.sv */
// ----------------------------------------------------------------------------
// ADC channel scan sequencer testbench
// Drives command words into the sequencer and checks every action word against
// a cycle-free model of the scan, hold and release behavior. A short directed
// sequence walks one full pass, the hold and release paths and a zero settle
// time; random phases then vary settle_ticks, idling on cmd and stalls on res.
// ----------------------------------------------------------------------------

typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_OPEN,
    SCAN_SETTLE,
    SCAN_TRIG_I,
    SCAN_READ_I,
    SCAN_TRIG_V,
    SCAN_READ_V,
    SCAN_CLOSE,
    SCAN_PARKED
} scan_phase_t;

typedef struct {
    acss_pkg::action_t                   action;
    logic [acss_pkg::CHAN_OUT_W-1:0]     channel;
    logic [acss_pkg::CODE_W-1:0]         code;
} scan_word_t;

class scan_action_tracker;

    int                             num_channels;
    scan_phase_t                    phase;
    logic [acss_pkg::SETTLE_W-1:0]  settle_ticks;
    logic [acss_pkg::SETTLE_W-1:0]  settle_count;
    int                             scan_channel;
    int                             saved_channel;
    int                             parked_channel;
    bit                             hold_active;
    scan_word_t                     expected_words[$];
    int                             errors;

    function new(int channels);
        num_channels   = channels;
        phase          = SCAN_IDLE;
        settle_ticks   = acss_pkg::SETTLE_RESET_VAL;
        settle_count   = '0;
        scan_channel   = 0;
        saved_channel  = 0;
        parked_channel = 0;
        hold_active    = 1'b0;
        errors         = 0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void push_word(acss_pkg::action_t action, int chan,
                            logic [acss_pkg::CODE_W-1:0] code);
        scan_word_t w;
        w.action  = action;
        w.channel = (action == acss_pkg::ACT_NONE) ? '0 : chan[acss_pkg::CHAN_OUT_W-1:0];
        w.code    = code;
        expected_words.push_back(w);
    endfunction

    function void step_tick(logic [acss_pkg::CODE_W-1:0] code);
        int ch;
        case (phase)
            SCAN_IDLE:
            begin
                phase        = SCAN_OPEN;
                settle_count = '0;
                scan_channel = 0;
                push_word(acss_pkg::ACT_NONE, 0, '0);
            end
            SCAN_OPEN:
            begin
                settle_count = '0;
                if (hold_active)
                begin
                    scan_channel = parked_channel;
                    phase        = SCAN_PARKED;
                    push_word(acss_pkg::ACT_OPEN_HOLD, scan_channel, '0);
                end
                else
                begin
                    phase = SCAN_SETTLE;
                    push_word(acss_pkg::ACT_OPEN, scan_channel, '0);
                end
            end
            SCAN_SETTLE:
            begin
                settle_count = settle_count + 1'b1;
                if (settle_count >= settle_ticks)
                begin
                    settle_count = '0;
                    phase        = SCAN_TRIG_I;
                    push_word(acss_pkg::ACT_START_CONV, scan_channel, '0);
                end
                else
                    push_word(acss_pkg::ACT_NONE, 0, '0);
            end
            SCAN_TRIG_I:
            begin
                phase = SCAN_READ_I;
                push_word(acss_pkg::ACT_TRIG_I, scan_channel, '0);
            end
            SCAN_READ_I:
            begin
                phase = SCAN_TRIG_V;
                push_word(acss_pkg::ACT_STORE_I, scan_channel, code);
            end
            SCAN_TRIG_V:
            begin
                phase = SCAN_READ_V;
                push_word(acss_pkg::ACT_TRIG_V, scan_channel, '0);
            end
            SCAN_READ_V:
            begin
                phase = SCAN_CLOSE;
                push_word(acss_pkg::ACT_STORE_V, scan_channel, code);
            end
            SCAN_CLOSE:
            begin
                ch = scan_channel;
                if (!hold_active)
                begin
                    scan_channel = scan_channel + 1;
                    if (scan_channel >= num_channels)
                        scan_channel = 0;
                end
                phase = SCAN_OPEN;
                push_word(acss_pkg::ACT_RESET_MUX, ch, '0);
            end
            SCAN_PARKED:
                push_word(acss_pkg::ACT_NONE, 0, '0);
            default:
            begin
                phase = SCAN_IDLE;
                push_word(acss_pkg::ACT_NONE, 0, '0);
            end
        endcase
    endfunction

    function void note_command(acss_pkg::cmd_t command,
                               logic [acss_pkg::HOLD_W-1:0] hold,
                               logic [acss_pkg::CODE_W-1:0] code);
        int hold_ch;
        hold_ch = hold;
        case (command)
            acss_pkg::CMD_HOLD:
            begin
                if (hold_ch >= num_channels)
                    hold_ch = num_channels - 1;
                saved_channel  = scan_channel;
                parked_channel = hold_ch;
                hold_active    = 1'b1;
                push_word(acss_pkg::ACT_NONE, 0, '0);
            end
            acss_pkg::CMD_RELEASE:
            begin
                scan_channel = saved_channel;
                hold_active  = 1'b0;
                phase        = SCAN_IDLE;
                push_word(acss_pkg::ACT_RESET_MUX, scan_channel, '0);
            end
            acss_pkg::CMD_TICK:
                step_tick(code);
            default:
                push_word(acss_pkg::ACT_NONE, 0, '0);
        endcase
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH: %s", msg);
    endtask

    task check_word(logic [acss_pkg::ACTION_W-1:0] action,
                    logic [acss_pkg::CHAN_OUT_W-1:0] channel,
                    logic [acss_pkg::CODE_W-1:0] code);
        scan_word_t w;
        if (expected_words.size() == 0)
        begin
            report($sformatf("unexpected word action %0d channel %0d code %h",
                             action, channel, code));
            return;
        end
        w = expected_words.pop_front();
        if (action !== w.action)
            report($sformatf("action %0d, expected %0d", action, w.action));
        if (channel !== w.channel)
            report($sformatf("channel %0d, expected %0d (action %0d)",
                             channel, w.channel, w.action));
        if (code !== w.code)
            report($sformatf("code %h, expected %h (action %0d)", code, w.code, w.action));
    endtask

endclass

module adc_channel_scan_sequencer_test;

    import acss_pkg::*;

    localparam int NUM_CHANNELS = DEF_CHANNELS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [SETTLE_W-1:0] cfg_wdata;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned cycle_count = 0;

    scan_action_tracker tracker = new(NUM_CHANNELS);

    acss_cmd_if cmd_ch ();
    acss_res_if res_ch ();

    adc_channel_scan_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd_ch),
        .res      (res_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.note_command(cmd_t'(cmd_ch.command), cmd_ch.hold_channel,
                                     cmd_ch.adc_code);
            if (res_ch.valid && res_ch.ready)
                tracker.check_word(res_ch.action, res_ch.channel, res_ch.code);
        end
    end

    task automatic send_command(cmd_t command, logic [HOLD_W-1:0] hold,
                                logic [CODE_W-1:0] code);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.command      <= cmd_t'($urandom_range(3));
            cmd_ch.hold_channel <= HOLD_W'($urandom);
            cmd_ch.adc_code     <= CODE_W'($urandom);
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= command;
        cmd_ch.hold_channel <= hold;
        cmd_ch.adc_code     <= code;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_settle_ticks(logic [SETTLE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.settle_ticks = value;
    endtask

    task automatic send_random_command(int ctrl_pct);
        int   r;
        cmd_t command;
        r = $urandom_range(99);
        if (r < ctrl_pct)
        begin
            case ($urandom_range(2))
                0:       command = CMD_HOLD;
                1:       command = CMD_RELEASE;
                default: command = CMD_UNUSED;
            endcase
        end
        else
            command = CMD_TICK;
        send_command(command, HOLD_W'($urandom), CODE_W'($urandom));
    endtask

    initial
    begin
        int settle_plan[NUM_PHASES];
        int ctrl_plan[NUM_PHASES];
        int count_plan[NUM_PHASES];
        int settle;

        settle_plan = '{1, 255, 2, 0, -1, 3, 1, -1};
        ctrl_plan   = '{6, 0, 6, 6, 6, 6, 10, 6};
        count_plan  = '{240, 300, 240, 240, 240, 240, 240, 240};

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_TICK;
        cmd_ch.hold_channel <= '0;
        cmd_ch.adc_code     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One pass at the reset settle time, with the hold taken before the close.
        for (int i = 0; i < 10; i++)
            send_command(CMD_TICK, HOLD_W'($urandom),
                         (i == 7) ? 24'h000000 : (i == 9) ? 24'hFFFFFF : 24'(i * 24'h111111));
        send_command(CMD_HOLD, 4'hF, 24'h000000);
        send_command(CMD_UNUSED, 4'hF, 24'hFFFFFF);
        send_command(CMD_TICK, 4'h0, 24'hFFFFFF);
        send_command(CMD_TICK, 4'h0, 24'h000000);
        send_command(CMD_TICK, 4'hF, 24'hFFFFFF);
        send_command(CMD_RELEASE, 4'h0, 24'hFFFFFF);
        send_command(CMD_TICK, 4'h0, 24'h000000);
        send_command(CMD_HOLD, 4'h0, 24'hFFFFFF);
        send_command(CMD_TICK, 4'hF, 24'h000000);
        send_command(CMD_RELEASE, 4'hF, 24'h000000);
        send_command(CMD_TICK, 4'h0, 24'h000000);
        drain();

        write_settle_ticks(8'd0);
        for (int i = 0; i < 6; i++)
            send_command(CMD_TICK, HOLD_W'($urandom), CODE_W'($urandom));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle = (settle_plan[p] < 0) ? $urandom_range(1, 255) : settle_plan[p];
            write_settle_ticks(settle[SETTLE_W-1:0]);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 45; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            for (int i = 0; i < count_plan[p]; i++)
                send_random_command(ctrl_plan[p]);
            drain();
            idle_pct  = 0;
            stall_pct = 0;
        end

        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
